[hdl/time_triggered_task_scheduler_unit_macros.svh]
`ifndef TIME_TRIGGERED_TASK_SCHEDULER_UNIT_MACROS_SVH
`define TIME_TRIGGERED_TASK_SCHEDULER_UNIT_MACROS_SVH

// concurrent check on i_clk, switched off while reset is low
`define TTTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// concurrent check on i_clk that also runs through reset
`define TTTS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[hdl/ttts_pkg.sv]
package ttts_pkg;

    // field widths of the stream payloads
    localparam int CMD_W       = 3;
    localparam int TAG_W       = 8;
    localparam int TIME_W      = 16;
    localparam int PEND_W      = 8;
    localparam int TICK_MS_W   = 10;
    localparam int SLOT_FLD_W  = 4;
    localparam int STATUS_W    = 2;
    localparam int TCOUNT_W    = 32;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 48;
    localparam int QCNT_W      = 5;

    localparam logic [PEND_W-1:0] PENDING_MAX = 8'hFF;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK       = 3'd0,
        CMD_ADD        = 3'd1,
        CMD_DELETE     = 3'd2,
        CMD_DISPATCH   = 3'd3,
        CMD_SET_PERIOD = 3'd4,
        CMD_QUERY      = 3'd5,
        CMD_READ_TICKS = 3'd6,
        CMD_NOP        = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // one table entry as stored in the slot ram
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] period;
        logic [PEND_W-1:0] pending;
    } t_slot;

    typedef struct packed {
        logic                  run_task;
        logic [TAG_W-1:0]      run_tag;
        logic [SLOT_FLD_W-1:0] slot_index;
        logic [STATUS_W-1:0]   status;
        logic                  scheduled;
        logic [TCOUNT_W-1:0]   tick_count;
        logic                  last;
    } t_result;

    // period divider request and response
    typedef struct packed {
        logic                 start;
        logic [TIME_W-1:0]    dividend;
        logic [TICK_MS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic [TIME_W-1:0] quotient;
    } t_div_rsp;

endpackage

[hdl/time_triggered_task_scheduler_unit.sv]
// time triggered task scheduler: slot table in one ram, walked one slot per cycle unless stalled
// every command walks the whole table, then its last result leaves from the done state
// one command at a time, taken only in idle, after the single read-modify-write ram walk
// dispatch results leave during the walk; a full output register stalls the walk on that slot
// add and set period also use the 16-step period divider, covered by the walk for 16+ slots
// reset (i_rst_n low, synchronous): slot valid bits cleared, tick counter 0, tick_ms 1
module time_triggered_task_scheduler_unit #(
    parameter int TASK_SLOTS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ttts_pkg::TICK_MS_W-1:0]       i_cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // task_tag[7:0], start_delay[23:8], repeat_ms[39:24]
    input  logic [ttts_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // command[2:0]
    input  logic [ttts_pkg::CMD_W-1:0]           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // run_tag[7:0], slot_index[11:8], status[13:12], scheduled[14],
    // tick_count[46:15], zero[47]
    output logic [ttts_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // run_task[0]
    output logic [0:0]                           m_axis_tuser,
    output logic                                 m_axis_tlast
);

    localparam int IDX_W  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
    localparam int SLOT_W = $bits(ttts_pkg::t_slot);

    // control registers
    ttts_pkg::t_state                    r_state, n_state;
    logic [CNT_W-1:0]                    r_issue;
    logic                                r_rd_vld;
    logic                                r_found;
    logic                                r_hold_vld;
    logic [TASK_SLOTS-1:0]               r_valid;
    logic [ttts_pkg::TCOUNT_W-1:0]       r_tick_cnt;
    logic [ttts_pkg::TICK_MS_W-1:0]      r_tick_ms;
    logic                                r_o_valid;

    // payload registers
    ttts_pkg::t_cmd                      r_cmd;
    logic [ttts_pkg::TAG_W-1:0]          r_tag;
    logic [ttts_pkg::TIME_W-1:0]         r_sdelay;
    logic [IDX_W-1:0]                    r_rd_idx;
    logic [IDX_W-1:0]                    r_found_idx;
    ttts_pkg::t_slot                     r_found_ent;
    logic [ttts_pkg::TAG_W-1:0]          r_hold_tag;
    logic [ttts_pkg::SLOT_FLD_W-1:0]     r_hold_slot;
    ttts_pkg::t_result                   r_o;

    // input unpacking
    ttts_pkg::t_cmd                      in_cmd;
    logic [ttts_pkg::TAG_W-1:0]          in_tag;
    logic [ttts_pkg::TIME_W-1:0]         in_sdelay;
    logic [ttts_pkg::TIME_W-1:0]         in_period;
    logic                                in_accept;

    // datapath control
    ttts_pkg::t_slot                     ent;
    ttts_pkg::t_slot                     upd;
    logic                                proc;
    logic                                tag_hit;
    logic                                need_emit;
    logic                                stall;
    logic                                advance;
    logic                                scan_end;
    logic                                done_fire;
    logic                                out_free;
    logic                                out_load;
    ttts_pkg::t_result                   out_data;
    logic                                found_take;
    logic                                hold_take;
    logic                                valid_set;
    logic                                valid_clr;
    logic [IDX_W-1:0]                    valid_idx;
    logic [7:0]                          rd_idx_ext;
    logic [7:0]                          found_idx_ext;

    // ram ports
    logic                                ram_re;
    logic [IDX_W-1:0]                    ram_raddr;
    logic                                ram_we;
    logic [IDX_W-1:0]                    ram_waddr;
    ttts_pkg::t_slot                     ram_wdata;
    logic [SLOT_W-1:0]                   ram_rdata;

    // divider
    ttts_pkg::t_div_req                  div_req;
    ttts_pkg::t_div_rsp                  div_rsp;

    assign in_cmd    = ttts_pkg::t_cmd'(s_axis_tuser);
    assign in_tag    = s_axis_tdata[7:0];
    assign in_sdelay = s_axis_tdata[23:8];
    assign in_period = s_axis_tdata[39:24];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    assign out_free  = !r_o_valid || m_axis_tready;
    assign scan_end  = (r_issue == CNT_W'(TASK_SLOTS)) && !r_rd_vld;
    assign done_fire = (r_state == ttts_pkg::S_DONE) && !div_rsp.busy && out_free;

    assign rd_idx_ext    = 8'(r_rd_idx);
    assign found_idx_ext = 8'(r_found_idx);

    // period in ms to ticks, zero tick_ms acts as one
    assign div_req.start    = in_accept &&
                              ((in_cmd == ttts_pkg::CMD_ADD) ||
                               (in_cmd == ttts_pkg::CMD_SET_PERIOD));
    assign div_req.dividend = in_period;
    assign div_req.divisor  = (r_tick_ms == '0) ? ttts_pkg::TICK_MS_W'(1) : r_tick_ms;

    ttts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    ttts_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TASK_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ttts_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = ttts_pkg::S_SCAN;
                end
            end
            ttts_pkg::S_SCAN: begin
                if (scan_end) begin
                    n_state = ttts_pkg::S_DONE;
                end
            end
            ttts_pkg::S_DONE: begin
                if (done_fire) begin
                    n_state = ttts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ttts_pkg::S_IDLE;
            end
        endcase
    end

    // walk control, slot update, ram writes and result selection
    always_comb begin
        ent        = r_valid[r_rd_idx] ? ttts_pkg::t_slot'(ram_rdata) : '0;
        upd        = ent;
        proc       = (r_state == ttts_pkg::S_SCAN) && r_rd_vld;
        tag_hit    = (r_cmd == ttts_pkg::CMD_ADD) ? (ent.tag == '0) :
                     ((r_tag != '0) && (ent.tag == r_tag));
        need_emit  = proc && (r_cmd == ttts_pkg::CMD_DISPATCH) && (ent.pending != '0);
        stall      = need_emit && r_hold_vld && !out_free;
        advance    = (r_state == ttts_pkg::S_SCAN) && !stall;
        ram_re     = advance && (r_issue < CNT_W'(TASK_SLOTS));
        ram_raddr  = r_issue[IDX_W-1:0];
        found_take = proc && !stall && !r_found && tag_hit;
        hold_take  = need_emit && !stall;

        ram_we     = 1'b0;
        ram_waddr  = r_rd_idx;
        ram_wdata  = ent;
        valid_set  = 1'b0;
        valid_clr  = 1'b0;
        valid_idx  = r_rd_idx;

        out_load            = 1'b0;
        out_data            = '0;
        out_data.tick_count = r_tick_cnt;

        // per-slot update during the walk
        if (proc && !stall) begin
            unique case (r_cmd)
                ttts_pkg::CMD_TICK: begin
                    if (ent.tag != '0) begin
                        if (ent.delay == '0) begin
                            if (ent.pending != ttts_pkg::PENDING_MAX) begin
                                upd.pending = ent.pending + 1'b1;
                            end
                            if (ent.period != '0) begin
                                upd.delay = ent.period - 1'b1;
                            end
                        end else begin
                            upd.delay = ent.delay - 1'b1;
                        end
                        ram_we = 1'b1;
                    end
                end
                ttts_pkg::CMD_DISPATCH: begin
                    if (need_emit) begin
                        upd.pending = ent.pending - 1'b1;
                        if (ent.period == '0) begin
                            valid_clr = 1'b1;
                        end else begin
                            ram_we = 1'b1;
                        end
                        // previous run order goes out, this one is held back
                        if (r_hold_vld) begin
                            out_load            = 1'b1;
                            out_data.run_task   = 1'b1;
                            out_data.run_tag    = r_hold_tag;
                            out_data.slot_index = r_hold_slot;
                        end
                    end
                end
                default: begin
                end
            endcase
            ram_wdata = upd;
        end

        // final result and table write after the walk
        if (done_fire) begin
            out_load      = 1'b1;
            out_data.last = 1'b1;
            unique case (r_cmd)
                ttts_pkg::CMD_TICK, ttts_pkg::CMD_READ_TICKS: begin
                    out_data.run_tag = r_tag;
                end
                ttts_pkg::CMD_ADD: begin
                    if (r_tag != '0) begin
                        out_data.run_tag = r_tag;
                        if (r_found) begin
                            out_data.slot_index = found_idx_ext[ttts_pkg::SLOT_FLD_W-1:0];
                            ram_we            = 1'b1;
                            ram_waddr         = r_found_idx;
                            ram_wdata.tag     = r_tag;
                            ram_wdata.delay   = r_sdelay;
                            ram_wdata.period  = div_rsp.quotient;
                            ram_wdata.pending = '0;
                            valid_set         = 1'b1;
                            valid_idx         = r_found_idx;
                        end else begin
                            out_data.status = ttts_pkg::STATUS_FULL;
                        end
                    end
                end
                ttts_pkg::CMD_DELETE: begin
                    out_data.run_tag = r_tag;
                    if (r_found) begin
                        out_data.slot_index = found_idx_ext[ttts_pkg::SLOT_FLD_W-1:0];
                        valid_clr           = 1'b1;
                        valid_idx           = r_found_idx;
                    end
                end
                ttts_pkg::CMD_DISPATCH: begin
                    if (r_hold_vld) begin
                        out_data.run_task   = 1'b1;
                        out_data.run_tag    = r_hold_tag;
                        out_data.slot_index = r_hold_slot;
                    end
                end
                ttts_pkg::CMD_SET_PERIOD: begin
                    out_data.run_tag = r_tag;
                    if (r_found) begin
                        out_data.slot_index = found_idx_ext[ttts_pkg::SLOT_FLD_W-1:0];
                        ram_we              = 1'b1;
                        ram_waddr           = r_found_idx;
                        ram_wdata           = r_found_ent;
                        ram_wdata.period    = div_rsp.quotient;
                    end else begin
                        out_data.status = ttts_pkg::STATUS_NOT_FOUND;
                    end
                end
                ttts_pkg::CMD_QUERY: begin
                    out_data.run_tag   = r_tag;
                    out_data.scheduled = r_found;
                end
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ttts_pkg::S_IDLE;
            r_issue    <= '0;
            r_rd_vld   <= 1'b0;
            r_found    <= 1'b0;
            r_hold_vld <= 1'b0;
            r_valid    <= '0;
            r_tick_cnt <= '0;
            r_tick_ms  <= ttts_pkg::TICK_MS_W'(1);
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_tick_ms <= i_cfg_wdata;
            end
            if (in_accept) begin
                r_issue    <= '0;
                r_rd_vld   <= 1'b0;
                r_found    <= 1'b0;
                r_hold_vld <= 1'b0;
                if (in_cmd == ttts_pkg::CMD_TICK) begin
                    r_tick_cnt <= r_tick_cnt + 1'b1;
                end
            end else if (advance) begin
                r_rd_vld <= ram_re;
                if (ram_re) begin
                    r_issue <= r_issue + 1'b1;
                end
            end
            if (found_take) begin
                r_found <= 1'b1;
            end
            if (hold_take) begin
                r_hold_vld <= 1'b1;
            end
            if (valid_clr) begin
                r_valid[valid_idx] <= 1'b0;
            end
            if (valid_set) begin
                r_valid[valid_idx] <= 1'b1;
            end
            // output register
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd    <= in_cmd;
            r_tag    <= in_tag;
            r_sdelay <= in_sdelay;
        end
        if (advance) begin
            r_rd_idx <= r_issue[IDX_W-1:0];
        end
        if (found_take) begin
            r_found_idx <= r_rd_idx;
            r_found_ent <= ent;
        end
        if (hold_take) begin
            r_hold_tag  <= ent.tag;
            r_hold_slot <= rd_idx_ext[ttts_pkg::SLOT_FLD_W-1:0];
        end
        if (out_load) begin
            r_o <= out_data;
        end
    end

    // stream outputs
    assign s_axis_tready = (r_state == ttts_pkg::S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {1'b0, r_o.tick_count, r_o.scheduled, r_o.status,
                            r_o.slot_index, r_o.run_tag};
    assign m_axis_tuser  = r_o.run_task;
    assign m_axis_tlast  = r_o.last;

endmodule

[hdl/ttts_ram.sv]
module ttts_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while no read is enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/ttts_div.sv]
module ttts_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ttts_pkg::t_div_req i_req,
    output ttts_pkg::t_div_rsp o_rsp
);

    logic                               r_busy;
    logic [ttts_pkg::QCNT_W-1:0]        r_cnt;
    logic [ttts_pkg::TIME_W-1:0]        r_quo;
    logic [ttts_pkg::TICK_MS_W-1:0]     r_rem;
    logic [ttts_pkg::TICK_MS_W-1:0]     r_div;
    logic [ttts_pkg::TICK_MS_W:0]       rem_sh;
    logic [ttts_pkg::TICK_MS_W:0]       diff;
    logic                               ge;
    logic [ttts_pkg::TICK_MS_W-1:0]     n_rem;

    // one restoring step: shift in the next dividend bit, trial subtract
    always_comb begin
        rem_sh = {r_rem, r_quo[ttts_pkg::TIME_W-1]};
        diff   = rem_sh - {1'b0, r_div};
        ge     = (rem_sh >= {1'b0, r_div});
        n_rem  = ge ? diff[ttts_pkg::TICK_MS_W-1:0] : rem_sh[ttts_pkg::TICK_MS_W-1:0];
    end

    // step counter and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= ttts_pkg::QCNT_W'(ttts_pkg::TIME_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == ttts_pkg::QCNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // dividend shifts out at the top while quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[ttts_pkg::TIME_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.quotient = r_quo;

endmodule

[hdl/ttts_checker.sv]
`include "time_triggered_task_scheduler_unit_macros.svh"

module ttts_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [ttts_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]                     m_axis_tuser,
    input logic                           m_axis_tlast
);

    // a stalled result keeps its valid and payload
    `TTTS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

    // one command at a time: ready drops after an input transaction
    `TTTS_ASSERT(a_one_cmd, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input accepted during a command")

    // every result that orders no run is the final one of its command
    `TTTS_ASSERT(a_plain_last, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast, "non-run result without last")

    // run orders carry ok status and no query answer
    `TTTS_ASSERT(a_run_fields, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[14:12] == 3'b000, "run order with status or scheduled set")

    // after reset the block is idle with no result shown
    `TTTS_ASSERT_RST(a_reset, !i_rst_n |=> !m_axis_tvalid && s_axis_tready, "not idle after reset")

endmodule

bind time_triggered_task_scheduler_unit ttts_checker u_checker (.*);
